### sv/jbt_pkg.sv
package jbt_pkg;

    localparam int JBT_LINE_BITS   = 24;
    localparam int JBT_COLUMN_BITS = 16;
    localparam int JBT_OUT_DEPTH   = 4;

    typedef enum logic [3:0] {
        KIND_LBRACE   = 4'd0,
        KIND_RBRACE   = 4'd1,
        KIND_LBRACKET = 4'd2,
        KIND_RBRACKET = 4'd3,
        KIND_COLON    = 4'd4,
        KIND_COMMA    = 4'd5,
        KIND_TRUE     = 4'd6,
        KIND_FALSE    = 4'd7,
        KIND_NULL     = 4'd8,
        KIND_STRING   = 4'd9,
        KIND_NUMBER   = 4'd10,
        KIND_ERROR    = 4'd11,
        KIND_END      = 4'd12
    } kind_t;

    typedef enum logic [10:0] {
        MODE_IDLE  = 11'b000_0000_0001,
        MODE_STR   = 11'b000_0000_0010,
        MODE_LIT_T = 11'b000_0000_0100,
        MODE_LIT_F = 11'b000_0000_1000,
        MODE_LIT_N = 11'b000_0001_0000,
        MODE_MINUS = 11'b000_0010_0000,
        MODE_ZERO  = 11'b000_0100_0000,
        MODE_INT   = 11'b000_1000_0000,
        MODE_FRAC  = 11'b001_0000_0000,
        MODE_EXP0  = 11'b010_0000_0000,
        MODE_EXPD  = 11'b100_0000_0000
    } mode_t;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } lit_sel_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       is_payload;
        logic       last_of_run;
    } tok_info_t;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_LOWER_E  = 8'h65;
    localparam logic [7:0] CH_UPPER_E  = 8'h45;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;

    function automatic logic [7:0] lit_char(input lit_sel_t sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (sel)
            LIT_TRUE:
                unique case (pos)
                    3'd0: ch = 8'h74;
                    3'd1: ch = 8'h72;
                    3'd2: ch = 8'h75;
                    3'd3: ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            LIT_FALSE:
                unique case (pos)
                    3'd0: ch = 8'h66;
                    3'd1: ch = 8'h61;
                    3'd2: ch = 8'h6C;
                    3'd3: ch = 8'h73;
                    3'd4: ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            LIT_NULL:
                unique case (pos)
                    3'd0: ch = 8'h6E;
                    3'd1: ch = 8'h75;
                    3'd2: ch = 8'h6C;
                    3'd3: ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input lit_sel_t sel);
        return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic kind_t lit_kind(input lit_sel_t sel);
        kind_t k;
        unique case (sel)
            LIT_TRUE:  k = KIND_TRUE;
            LIT_FALSE: k = KIND_FALSE;
            default:   k = KIND_NULL;
        endcase
        return k;
    endfunction

    function automatic tok_info_t mk_tok(input kind_t kind);
        tok_info_t t;
        t.kind         = kind;
        t.payload_byte = 8'h00;
        t.is_payload   = 1'b0;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    function automatic tok_info_t mk_pay(input kind_t kind, input logic [7:0] ch);
        tok_info_t t;
        t.kind         = kind;
        t.payload_byte = ch;
        t.is_payload   = 1'b1;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

### sv/jbt_in_if.sv
interface jbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

### sv/jbt_out_if.sv
interface jbt_out_if
    import jbt_pkg::*;
#(
    parameter int LINE_BITS   = JBT_LINE_BITS,
    parameter int COLUMN_BITS = JBT_COLUMN_BITS
);
    logic                   valid;
    logic                   ready;
    logic [3:0]             token_kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [7:0]             payload_byte;
    logic                   is_payload;
    logic                   last_of_run;

    modport source (output valid, output token_kind, output start_line,
                    output start_column, output payload_byte, output is_payload,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_line,
                  input start_column, input payload_byte, input is_payload,
                  input last_of_run, output ready);
endinterface

### sv/json_byte_tokenizer_top.sv
// JSON byte tokenizer. Feed one text byte per word on text_in, or a word with
// end_of_text set to close the stream; token_out returns string and number
// bytes as payload words, followed by the token word (punctuation, true, false,
// null, string, number, error, end) with its start line and column. A byte is
// taken every clock as long as token_out takes a word every clock and each byte
// gives at most one word; a byte that both closes a number and opens a new
// token, or an end mark behind a pending token, gives two words, which leave
// one after another through the single output port. The byte goes through an
// input register and one pass of lexer logic into a four-word output queue; it
// waits in the input register while the queue lacks room for two words. Line
// and column counters stop at their largest value.
module json_byte_tokenizer_top
    import jbt_pkg::*;
#(
    parameter int LINE_BITS   = JBT_LINE_BITS,
    parameter int COLUMN_BITS = JBT_COLUMN_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    jbt_in_if.sink     text_in,
    jbt_out_if.source  token_out
);

    localparam int InfoBits = $bits(tok_info_t);
    localparam int DataBits = LINE_BITS + COLUMN_BITS + InfoBits;

    logic                   room;
    logic [1:0]             res_cnt;
    tok_info_t              res_info [2];
    logic [LINE_BITS-1:0]   res_line [2];
    logic [COLUMN_BITS-1:0] res_col [2];
    logic [DataBits-1:0]    push_data [2];
    logic [DataBits-1:0]    out_data;
    tok_info_t              out_info;

    jbt_lexer #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .room     (room),
        .res_cnt  (res_cnt),
        .res_info (res_info),
        .res_line (res_line),
        .res_col  (res_col)
    );

    assign push_data[0] = {res_line[0], res_col[0], res_info[0]};
    assign push_data[1] = {res_line[1], res_col[1], res_info[1]};

    jbt_out_fifo #(
        .DATA_BITS (DataBits)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .push_data (push_data),
        .room      (room),
        .out_valid (token_out.valid),
        .out_ready (token_out.ready),
        .out_data  (out_data)
    );

    assign out_info               = tok_info_t'(out_data[InfoBits-1:0]);
    assign token_out.token_kind   = out_info.kind;
    assign token_out.payload_byte = out_info.payload_byte;
    assign token_out.is_payload   = out_info.is_payload;
    assign token_out.last_of_run  = out_info.last_of_run;
    assign token_out.start_column = out_data[InfoBits +: COLUMN_BITS];
    assign token_out.start_line   = out_data[InfoBits + COLUMN_BITS +: LINE_BITS];

endmodule

### sv/jbt_lexer.sv
module jbt_lexer
    import jbt_pkg::*;
#(
    parameter int LINE_BITS   = JBT_LINE_BITS,
    parameter int COLUMN_BITS = JBT_COLUMN_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    jbt_in_if.sink                 text_in,
    input  logic                   room,
    output logic [1:0]             res_cnt,
    output tok_info_t              res_info [2],
    output logic [LINE_BITS-1:0]   res_line [2],
    output logic [COLUMN_BITS-1:0] res_col [2]
);

    localparam logic [LINE_BITS-1:0]   LineMax = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] ColMax  = {COLUMN_BITS{1'b1}};

    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   eot_reg;
    logic                   advance;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [2:0]             lit_pos_reg, lit_pos_next;
    logic                   esc_reg, esc_next;
    logic                   digit_reg, digit_next;

    logic [7:0]             c;
    logic                   c_digit, c_ws, c_exp;
    logic [LINE_BITS-1:0]   line_adv;
    logic [COLUMN_BITS-1:0] col_adv;
    lit_sel_t               lit_sel;

    // start-of-token decode for the current byte
    mode_t                  sb_mode;
    logic                   sb_emit;
    tok_info_t              sb_info;

    logic [1:0]             n_res;
    logic                   do_start;
    logic                   pre_tok;

    assign advance       = in_valid_reg && room;
    assign text_in.ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text_in.valid && text_in.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            byte_reg <= text_in.text_byte;
            eot_reg  <= text_in.end_of_text;
        end
    end

    assign c       = byte_reg;
    assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign c_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    assign c_exp   = (c == CH_LOWER_E) || (c == CH_UPPER_E);

    always_comb
    begin
        line_adv = line_reg;
        col_adv  = col_reg;
        if (c == CH_LF)
        begin
            line_adv = (line_reg == LineMax) ? line_reg : line_reg + 1'b1;
            col_adv  = '0;
        end
        else if (col_reg != ColMax)
        begin
            col_adv = col_reg + 1'b1;
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_LIT_F: lit_sel = LIT_FALSE;
            MODE_LIT_N: lit_sel = LIT_NULL;
            default:    lit_sel = LIT_TRUE;
        endcase
    end

    always_comb
    begin
        sb_mode = MODE_IDLE;
        sb_emit = 1'b1;
        sb_info = mk_tok(KIND_ERROR);
        priority if (c_ws)
        begin
            sb_emit = 1'b0;
        end
        else if (c == CH_LBRACE)   sb_info = mk_tok(KIND_LBRACE);
        else if (c == CH_RBRACE)   sb_info = mk_tok(KIND_RBRACE);
        else if (c == CH_LBRACKET) sb_info = mk_tok(KIND_LBRACKET);
        else if (c == CH_RBRACKET) sb_info = mk_tok(KIND_RBRACKET);
        else if (c == CH_COLON)    sb_info = mk_tok(KIND_COLON);
        else if (c == CH_COMMA)    sb_info = mk_tok(KIND_COMMA);
        else if (c == CH_QUOTE)
        begin
            sb_mode = MODE_STR;
            sb_emit = 1'b0;
        end
        else if (c == CH_T)
        begin
            sb_mode = MODE_LIT_T;
            sb_emit = 1'b0;
        end
        else if (c == CH_F)
        begin
            sb_mode = MODE_LIT_F;
            sb_emit = 1'b0;
        end
        else if (c == CH_N)
        begin
            sb_mode = MODE_LIT_N;
            sb_emit = 1'b0;
        end
        else if (c == CH_MINUS)
        begin
            sb_mode = MODE_MINUS;
            sb_info = mk_pay(KIND_NUMBER, c);
        end
        else if (c_digit)
        begin
            sb_mode = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
            sb_info = mk_pay(KIND_NUMBER, c);
        end
        else
        begin
            sb_info = mk_tok(KIND_ERROR);
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        lit_pos_next  = lit_pos_reg;
        esc_next      = esc_reg;
        digit_next    = digit_reg;
        n_res         = 2'd0;
        do_start      = 1'b0;
        pre_tok       = 1'b0;
        res_info[0]   = mk_tok(KIND_NUMBER);
        res_info[1]   = mk_tok(KIND_END);
        res_line[0]   = tok_line_reg;
        res_line[1]   = tok_line_reg;
        res_col[0]    = tok_col_reg;
        res_col[1]    = tok_col_reg;

        if (eot_reg)
        begin
            // close any pending token, then the end word
            n_res = 2'd1;
            unique case (mode_reg)
                MODE_STR:
                begin
                    res_info[0] = mk_tok(KIND_STRING);
                    n_res       = 2'd2;
                end
                MODE_ZERO, MODE_INT:
                begin
                    res_info[0] = mk_tok(KIND_NUMBER);
                    n_res       = 2'd2;
                end
                MODE_FRAC, MODE_EXPD:
                begin
                    res_info[0] = mk_tok(digit_reg ? KIND_NUMBER : KIND_ERROR);
                    n_res       = 2'd2;
                end
                MODE_LIT_T, MODE_LIT_F, MODE_LIT_N, MODE_MINUS, MODE_EXP0:
                begin
                    res_info[0] = mk_tok(KIND_ERROR);
                    n_res       = 2'd2;
                end
                default: n_res = 2'd1;
            endcase
            res_info[n_res[1]] = mk_tok(KIND_END);
            res_line[n_res[1]] = line_reg;
            res_col[n_res[1]]  = (col_reg == ColMax) ? col_reg : col_reg + 1'b1;
            mode_next     = MODE_IDLE;
            line_next     = LINE_BITS'(1);
            col_next      = '0;
            tok_line_next = LINE_BITS'(1);
            tok_col_next  = COLUMN_BITS'(1);
            lit_pos_next  = 3'd0;
            esc_next      = 1'b0;
            digit_next    = 1'b0;
        end
        else
        begin
            line_next = line_adv;
            col_next  = col_adv;
            unique case (mode_reg)
                MODE_STR:
                begin
                    n_res = 2'd1;
                    if (esc_reg)
                    begin
                        esc_next    = 1'b0;
                        res_info[0] = mk_pay(KIND_STRING, c);
                    end
                    else if (c == CH_QUOTE)
                    begin
                        res_info[0] = mk_tok(KIND_STRING);
                        mode_next   = MODE_IDLE;
                    end
                    else
                    begin
                        esc_next    = (c == CH_BSLASH);
                        res_info[0] = mk_pay(KIND_STRING, c);
                    end
                end
                MODE_LIT_T, MODE_LIT_F, MODE_LIT_N:
                begin
                    if ((lit_pos_reg < lit_len(lit_sel)) && (c == lit_char(lit_sel, lit_pos_reg)))
                    begin
                        lit_pos_next = lit_pos_reg + 1'b1;
                        if (lit_pos_reg + 3'd1 == lit_len(lit_sel))
                        begin
                            n_res        = 2'd1;
                            res_info[0]  = mk_tok(lit_kind(lit_sel));
                            mode_next    = MODE_IDLE;
                            lit_pos_next = 3'd0;
                        end
                    end
                    else
                    begin
                        // drop the wrong byte, flag the literal
                        n_res        = 2'd1;
                        res_info[0]  = mk_tok(KIND_ERROR);
                        mode_next    = MODE_IDLE;
                        lit_pos_next = 3'd0;
                    end
                end
                MODE_MINUS:
                begin
                    n_res = 2'd1;
                    if (c_digit)
                    begin
                        mode_next   = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
                        res_info[0] = mk_pay(KIND_NUMBER, c);
                    end
                    else
                    begin
                        res_info[0] = mk_tok(KIND_ERROR);
                        mode_next   = MODE_IDLE;
                    end
                end
                MODE_ZERO, MODE_INT:
                begin
                    n_res = 2'd1;
                    if (c_digit && (mode_reg == MODE_INT))
                    begin
                        res_info[0] = mk_pay(KIND_NUMBER, c);
                    end
                    else if (c == CH_DOT)
                    begin
                        mode_next   = MODE_FRAC;
                        digit_next  = 1'b0;
                        res_info[0] = mk_pay(KIND_NUMBER, c);
                    end
                    else if (c_exp)
                    begin
                        mode_next   = MODE_EXP0;
                        res_info[0] = mk_pay(KIND_NUMBER, CH_LOWER_E);
                    end
                    else
                    begin
                        res_info[0] = mk_tok(KIND_NUMBER);
                        do_start    = 1'b1;
                        pre_tok     = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    n_res = 2'd1;
                    if (c_digit)
                    begin
                        digit_next  = 1'b1;
                        res_info[0] = mk_pay(KIND_NUMBER, c);
                    end
                    else if (!digit_reg)
                    begin
                        res_info[0] = mk_tok(KIND_ERROR);
                        mode_next   = MODE_IDLE;
                    end
                    else if (c_exp)
                    begin
                        mode_next   = MODE_EXP0;
                        res_info[0] = mk_pay(KIND_NUMBER, CH_LOWER_E);
                    end
                    else
                    begin
                        res_info[0] = mk_tok(KIND_NUMBER);
                        do_start    = 1'b1;
                        pre_tok     = 1'b1;
                    end
                end
                MODE_EXP0:
                begin
                    n_res = 2'd1;
                    if ((c == CH_PLUS) || (c == CH_MINUS))
                    begin
                        mode_next   = MODE_EXPD;
                        digit_next  = 1'b0;
                        res_info[0] = mk_pay(KIND_NUMBER, c);
                    end
                    else if (c_digit)
                    begin
                        mode_next   = MODE_EXPD;
                        digit_next  = 1'b1;
                        res_info[0] = mk_pay(KIND_NUMBER, c);
                    end
                    else
                    begin
                        res_info[0] = mk_tok(KIND_ERROR);
                        mode_next   = MODE_IDLE;
                    end
                end
                MODE_EXPD:
                begin
                    n_res = 2'd1;
                    if (c_digit)
                    begin
                        digit_next  = 1'b1;
                        res_info[0] = mk_pay(KIND_NUMBER, c);
                    end
                    else if (digit_reg)
                    begin
                        res_info[0] = mk_tok(KIND_NUMBER);
                        do_start    = 1'b1;
                        pre_tok     = 1'b1;
                    end
                    else
                    begin
                        res_info[0] = mk_tok(KIND_ERROR);
                        mode_next   = MODE_IDLE;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            // byte that opens the next token, after any number it closed
            if (do_start)
            begin
                mode_next = sb_mode;
                if (!c_ws)
                begin
                    tok_line_next = line_adv;
                    tok_col_next  = col_adv;
                end
                if ((sb_mode == MODE_LIT_T) || (sb_mode == MODE_LIT_F) ||
                    (sb_mode == MODE_LIT_N))
                begin
                    lit_pos_next = 3'd1;
                end
                if (sb_mode == MODE_STR)
                begin
                    esc_next = 1'b0;
                end
                if (sb_emit)
                begin
                    res_info[pre_tok] = sb_info;
                    res_line[pre_tok] = line_adv;
                    res_col[pre_tok]  = col_adv;
                    n_res             = pre_tok ? 2'd2 : 2'd1;
                end
            end
        end

        res_info[0].last_of_run = (n_res == 2'd1);
        res_info[1].last_of_run = 1'b1;
    end

    assign res_cnt = advance ? n_res : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            line_reg     <= LINE_BITS'(1);
            col_reg      <= '0;
            tok_line_reg <= LINE_BITS'(1);
            tok_col_reg  <= COLUMN_BITS'(1);
            lit_pos_reg  <= 3'd0;
            esc_reg      <= 1'b0;
            digit_reg    <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            lit_pos_reg  <= lit_pos_next;
            esc_reg      <= esc_next;
            digit_reg    <= digit_next;
        end
    end

endmodule

### sv/jbt_out_fifo.sv
module jbt_out_fifo
    import jbt_pkg::*;
#(
    parameter int DATA_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_cnt,
    input  logic [DATA_BITS-1:0] push_data [2],
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] out_data
);

    localparam int PtrBits = $clog2(JBT_OUT_DEPTH);
    localparam int CntBits = $clog2(JBT_OUT_DEPTH + 1);

    logic [DATA_BITS-1:0] mem_reg [JBT_OUT_DEPTH];
    logic [PtrBits-1:0]   wptr_reg, wptr_next;
    logic [PtrBits-1:0]   rptr_reg, rptr_next;
    logic [CntBits-1:0]   count_reg, count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    // keep space for the two words one byte may raise
    assign room      = (count_reg <= CntBits'(JBT_OUT_DEPTH - 2));

    assign wptr_next  = wptr_reg + PtrBits'(push_cnt);
    assign rptr_next  = rptr_reg + PtrBits'(pop);
    assign count_next = count_reg + CntBits'(push_cnt) - CntBits'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wptr_reg] <= push_data[0];
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[PtrBits'(wptr_reg + 1'b1)] <= push_data[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### bench/jbt_token_checker.sv
module jbt_token_checker
    import jbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jbt_in_if    text_in,
    jbt_out_if   token_out,
    output int   failures,
    output int   outstanding,
    output int   words_checked
);

    localparam logic [JBT_LINE_BITS-1:0]   LINE_TOP   = '1;
    localparam logic [JBT_COLUMN_BITS-1:0] COLUMN_TOP = '1;

    typedef struct packed {
        kind_t                      kind;
        logic [JBT_LINE_BITS-1:0]   line;
        logic [JBT_COLUMN_BITS-1:0] column;
        logic [7:0]                 payload;
        logic                       is_payload;
        logic                       last;
    } token_word_t;

    token_word_t expected_words[$];

    // lexer state as seen from the input stream
    mode_t                      lx_mode;
    logic [JBT_LINE_BITS-1:0]   cur_line;
    logic [JBT_COLUMN_BITS-1:0] cur_col;
    logic [JBT_LINE_BITS-1:0]   tok_line;
    logic [JBT_COLUMN_BITS-1:0] tok_col;
    logic [2:0]                 lit_pos;
    logic                       esc_pending;
    logic                       digit_seen;

    initial
    begin
        failures      = 0;
        outstanding   = 0;
        words_checked = 0;
    end

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void reset_lexer();
        lx_mode     = MODE_IDLE;
        cur_line    = JBT_LINE_BITS'(1);
        cur_col     = '0;
        tok_line    = JBT_LINE_BITS'(1);
        tok_col     = JBT_COLUMN_BITS'(1);
        lit_pos     = 3'd0;
        esc_pending = 1'b0;
        digit_seen  = 1'b0;
    endfunction

    function automatic void emit_word(input kind_t kind, input logic [JBT_LINE_BITS-1:0] ln,
                                      input logic [JBT_COLUMN_BITS-1:0] col,
                                      input logic [7:0] b, input logic isp);
        token_word_t w;
        w.kind       = kind;
        w.line       = ln;
        w.column     = col;
        w.payload    = b;
        w.is_payload = isp;
        w.last       = 1'b0;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void emit_token(input kind_t kind);
        emit_word(kind, tok_line, tok_col, 8'h00, 1'b0);
    endfunction

    function automatic void emit_number_byte(input logic [7:0] b);
        emit_word(KIND_NUMBER, tok_line, tok_col, b, 1'b1);
    endfunction

    function automatic void open_token(input logic [7:0] c);
        lx_mode = MODE_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
            return;
        tok_line = cur_line;
        tok_col  = cur_col;
        case (c)
            CH_LBRACE:   emit_token(KIND_LBRACE);
            CH_RBRACE:   emit_token(KIND_RBRACE);
            CH_LBRACKET: emit_token(KIND_LBRACKET);
            CH_RBRACKET: emit_token(KIND_RBRACKET);
            CH_COLON:    emit_token(KIND_COLON);
            CH_COMMA:    emit_token(KIND_COMMA);
            CH_QUOTE:
            begin
                lx_mode     = MODE_STR;
                esc_pending = 1'b0;
            end
            CH_T:
            begin
                lx_mode = MODE_LIT_T;
                lit_pos = 3'd1;
            end
            CH_F:
            begin
                lx_mode = MODE_LIT_F;
                lit_pos = 3'd1;
            end
            CH_N:
            begin
                lx_mode = MODE_LIT_N;
                lit_pos = 3'd1;
            end
            CH_MINUS:
            begin
                lx_mode = MODE_MINUS;
                emit_number_byte(c);
            end
            default:
            begin
                if (is_numeral(c))
                begin
                    lx_mode = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
                    emit_number_byte(c);
                end
                else
                    emit_token(KIND_ERROR);
            end
        endcase
    endfunction

    // fraction or exponent may follow the integer part; anything else ends the number
    function automatic void after_integer(input logic [7:0] c);
        if (c == CH_DOT)
        begin
            lx_mode    = MODE_FRAC;
            digit_seen = 1'b0;
            emit_number_byte(c);
        end
        else if (c == CH_LOWER_E || c == CH_UPPER_E)
        begin
            lx_mode = MODE_EXP0;
            emit_number_byte(CH_LOWER_E);
        end
        else
        begin
            emit_token(KIND_NUMBER);
            open_token(c);
        end
    endfunction

    function automatic void lex_text_byte(input logic [7:0] c);
        string spelled;
        kind_t done_kind;
        if (c == CH_LF)
        begin
            if (cur_line != LINE_TOP)
                cur_line++;
            cur_col = '0;
        end
        else if (cur_col != COLUMN_TOP)
            cur_col++;

        case (lx_mode)
            MODE_STR:
            begin
                if (esc_pending)
                begin
                    esc_pending = 1'b0;
                    emit_word(KIND_STRING, tok_line, tok_col, c, 1'b1);
                end
                else if (c == CH_QUOTE)
                begin
                    emit_token(KIND_STRING);
                    lx_mode = MODE_IDLE;
                end
                else
                begin
                    if (c == CH_BSLASH)
                        esc_pending = 1'b1;
                    emit_word(KIND_STRING, tok_line, tok_col, c, 1'b1);
                end
            end
            MODE_LIT_T, MODE_LIT_F, MODE_LIT_N:
            begin
                case (lx_mode)
                    MODE_LIT_T:
                    begin
                        spelled   = "true";
                        done_kind = KIND_TRUE;
                    end
                    MODE_LIT_F:
                    begin
                        spelled   = "false";
                        done_kind = KIND_FALSE;
                    end
                    default:
                    begin
                        spelled   = "null";
                        done_kind = KIND_NULL;
                    end
                endcase
                if (lit_pos < spelled.len() && c == 8'(spelled[lit_pos]))
                begin
                    lit_pos++;
                    if (lit_pos == spelled.len())
                    begin
                        emit_token(done_kind);
                        lx_mode = MODE_IDLE;
                        lit_pos = 3'd0;
                    end
                end
                else
                begin
                    // report at the literal's start and drop the wrong byte
                    emit_token(KIND_ERROR);
                    lx_mode = MODE_IDLE;
                    lit_pos = 3'd0;
                end
            end
            MODE_MINUS:
            begin
                if (is_numeral(c))
                begin
                    lx_mode = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
                    emit_number_byte(c);
                end
                else
                begin
                    emit_token(KIND_ERROR);
                    lx_mode = MODE_IDLE;
                end
            end
            MODE_ZERO:
                after_integer(c);
            MODE_INT:
            begin
                if (is_numeral(c))
                    emit_number_byte(c);
                else
                    after_integer(c);
            end
            MODE_FRAC:
            begin
                if (is_numeral(c))
                begin
                    digit_seen = 1'b1;
                    emit_number_byte(c);
                end
                else if (!digit_seen)
                begin
                    emit_token(KIND_ERROR);
                    lx_mode = MODE_IDLE;
                end
                else if (c == CH_LOWER_E || c == CH_UPPER_E)
                begin
                    lx_mode = MODE_EXP0;
                    emit_number_byte(CH_LOWER_E);
                end
                else
                begin
                    emit_token(KIND_NUMBER);
                    open_token(c);
                end
            end
            MODE_EXP0:
            begin
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    lx_mode    = MODE_EXPD;
                    digit_seen = 1'b0;
                    emit_number_byte(c);
                end
                else if (is_numeral(c))
                begin
                    lx_mode    = MODE_EXPD;
                    digit_seen = 1'b1;
                    emit_number_byte(c);
                end
                else
                begin
                    emit_token(KIND_ERROR);
                    lx_mode = MODE_IDLE;
                end
            end
            MODE_EXPD:
            begin
                if (is_numeral(c))
                begin
                    digit_seen = 1'b1;
                    emit_number_byte(c);
                end
                else if (digit_seen)
                begin
                    emit_token(KIND_NUMBER);
                    open_token(c);
                end
                else
                begin
                    emit_token(KIND_ERROR);
                    lx_mode = MODE_IDLE;
                end
            end
            default:
                open_token(c);
        endcase
    endfunction

    function automatic void lex_end_of_text();
        if (lx_mode == MODE_STR)
            emit_token(KIND_STRING);
        else if (lx_mode == MODE_ZERO || lx_mode == MODE_INT ||
                 ((lx_mode == MODE_FRAC || lx_mode == MODE_EXPD) && digit_seen))
            emit_token(KIND_NUMBER);
        else if (lx_mode != MODE_IDLE)
            emit_token(KIND_ERROR);
        emit_word(KIND_END, cur_line, (cur_col != COLUMN_TOP) ? cur_col + 1'b1 : cur_col,
                  8'h00, 1'b0);
        reset_lexer();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        token_word_t want;
        int          before_n;
        if (!rst_n)
        begin
            reset_lexer();
            expected_words.delete();
        end
        else
        begin
            if (text_in.valid && text_in.ready)
            begin
                before_n = expected_words.size();
                if (text_in.end_of_text)
                    lex_end_of_text();
                else
                    lex_text_byte(text_in.text_byte);
                // flag the final word caused by this input
                if (expected_words.size() > before_n)
                    expected_words[expected_words.size() - 1].last = 1'b1;
            end
            if (token_out.valid && token_out.ready)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output word: token_kind %0d", token_out.token_kind);
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("token_kind", want.kind, token_out.token_kind);
                    check_field("start_line", want.line, token_out.start_line);
                    check_field("start_column", want.column, token_out.start_column);
                    check_field("payload_byte", want.payload, token_out.payload_byte);
                    check_field("is_payload", want.is_payload, token_out.is_payload);
                    check_field("last_of_run", want.last, token_out.last_of_run);
                end
            end
        end
        outstanding <= expected_words.size();
    end

endmodule

### bench/testbench.sv
module testbench;
    import jbt_pkg::*;

    localparam int RANDOM_ITEMS    = 1050;
    localparam int QUIET_TAIL      = 150;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int failures;
    int outstanding;
    int words_checked;
    int items_sent   = 0;
    int end_marks    = 0;
    int cycles       = 0;
    bit gaps_on      = 1'b0;
    bit stalls_on    = 1'b0;
    bit hold_off_req = 1'b0;

    jbt_in_if  text_in();
    jbt_out_if token_out();

    json_byte_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .token_out (token_out)
    );

    jbt_token_checker token_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_in       (text_in),
        .token_out     (token_out),
        .failures      (failures),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d words outstanding", cycles, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        token_out.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                token_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                token_out.ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                token_out.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                token_out.ready <= 1'b1;
            end
            else
                token_out.ready <= 1'b1;
        end
    end

    task automatic put_word(input logic [7:0] b, input logic eot);
        text_in.valid       <= 1'b1;
        text_in.text_byte   <= b;
        text_in.end_of_text <= eot;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
        items_sent++;
        if (eot)
            end_marks++;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            text_in.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_word(s[i], 1'b0);
    endtask

    task automatic send_end();
        put_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        text_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_literal(input bit broken);
        string spelled;
        int    cut;
        case ($urandom_range(0, 2))
            0:       spelled = "true";
            1:       spelled = "false";
            default: spelled = "null";
        endcase
        cut = broken ? $urandom_range(1, spelled.len() - 1) : spelled.len();
        for (int i = 0; i < cut; i++)
            put_word(spelled[i], 1'b0);
        if (broken && $urandom_range(0, 1) == 1)
            put_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_string();
        int len;
        len = $urandom_range(0, 8);
        put_word(CH_QUOTE, 1'b0);
        repeat (len)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    put_word(CH_BSLASH, 1'b0);
                    put_word(8'($urandom_range(0, 255)), 1'b0);
                end
                1:       put_word(8'($urandom_range(0, 255)), 1'b0);
                default: put_word(CH_SPACE + 8'($urandom_range(0, 94)), 1'b0);
            endcase
        end
        // leave some strings open
        if ($urandom_range(0, 9) != 0)
            put_word(CH_QUOTE, 1'b0);
    endtask

    // flaw: 0 drops the digit after minus, 1 after the dot, 2 after the exponent
    task automatic send_number(input bit broken);
        int flaw;
        flaw = broken ? $urandom_range(0, 2) : 3;
        if (flaw == 0 || $urandom_range(0, 2) == 0)
            put_word(CH_MINUS, 1'b0);
        if (flaw == 0)
            return;
        if ($urandom_range(0, 3) == 0)
            put_word(CH_ZERO, 1'b0);
        else
        begin
            put_word(CH_ZERO + 8'($urandom_range(1, 9)), 1'b0);
            repeat ($urandom_range(0, 5)) put_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
        if (flaw == 1 || $urandom_range(0, 2) == 0)
        begin
            put_word(CH_DOT, 1'b0);
            if (flaw == 1)
                return;
            repeat ($urandom_range(1, 4)) put_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
        if (flaw == 2 || $urandom_range(0, 2) == 0)
        begin
            put_word($urandom_range(0, 1) ? CH_UPPER_E : CH_LOWER_E, 1'b0);
            case ($urandom_range(0, 2))
                0:       put_word(CH_PLUS, 1'b0);
                1:       put_word(CH_MINUS, 1'b0);
                default: ;
            endcase
            if (flaw == 2)
                return;
            repeat ($urandom_range(1, 3)) put_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
    endtask

    task automatic send_punctuation();
        case ($urandom_range(0, 5))
            0:       put_word(CH_LBRACE, 1'b0);
            1:       put_word(CH_RBRACE, 1'b0);
            2:       put_word(CH_LBRACKET, 1'b0);
            3:       put_word(CH_RBRACKET, 1'b0);
            4:       put_word(CH_COLON, 1'b0);
            default: put_word(CH_COMMA, 1'b0);
        endcase
    endtask

    task automatic send_blank();
        case ($urandom_range(0, 3))
            0:       put_word(CH_SPACE, 1'b0);
            1:       put_word(CH_TAB, 1'b0);
            2:       put_word(CH_LF, 1'b0);
            default: put_word(CH_CR, 1'b0);
        endcase
    endtask

    initial
    begin
        int  random_goal;
        bit  hold_done;
        bit  pause_done;
        text_in.valid       = 1'b0;
        text_in.text_byte   = 8'h00;
        text_in.end_of_text = 1'b0;
        hold_done           = 1'b0;
        pause_done          = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: punctuation, open literal at end, literal mismatch, escaped quote,
        // leading zero split, bad minus, stray bytes, full number closed by a tab
        send_text("[{:,}]\n");
        send_text("tru");
        send_end();
        send_text("fa1\"\\\"\"01-x");
        put_word(8'h00, 1'b0);
        put_word(8'hFF, 1'b0);
        send_text("1.5E+3\t");
        send_end();

        // a new line, then an open number closed by the end mark
        put_word(CH_LF, 1'b0);
        send_text("{7");
        send_end();
        wait_drained();

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (items_sent >= random_goal - QUIET_TAIL)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            case ($urandom_range(0, 19))
                0, 1, 2:        send_punctuation();
                3, 4:           send_blank();
                5, 6, 7:        send_literal(1'b0);
                8, 9, 10, 11:   send_string();
                12, 13, 14, 15: send_number(1'b0);
                16, 17:         put_word(8'($urandom_range(0, 255)), 1'b0);
                18:             send_end();
                default:
                begin
                    if ($urandom_range(0, 1) == 1)
                        send_number(1'b1);
                    else
                        send_literal(1'b1);
                end
            endcase
            // keep offering digits while the output side holds off
            if (!hold_done && items_sent >= random_goal - RANDOM_ITEMS + 300)
            begin
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
                put_word(CH_ZERO + 8'd1, 1'b0);
                repeat (40) put_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                put_word(CH_COMMA, 1'b0);
            end
            if (!pause_done && items_sent >= random_goal - RANDOM_ITEMS + 600)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
        end
        send_end();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d input words (%0d end marks); compared %0d output words.",
                 items_sent, end_marks, words_checked);
        $display("Covered all token kinds, escapes, bad numbers and literals, stray bytes,");
        $display("a long output stall and a full drain mid-run.");
        if (failures == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
